[rtl/knob_level_quantizer_hysteresis_unit_defines.svh]
// assertion macros for the knob level quantizer
// used by knob_level_quantizer_hysteresis_unit, expects clk and rst_n in scope
`ifndef KNOB_LEVEL_QUANTIZER_HYSTERESIS_UNIT_DEFINES_SVH
`define KNOB_LEVEL_QUANTIZER_HYSTERESIS_UNIT_DEFINES_SVH

// same-cycle implication
`define KLQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("knob level quantizer assertion failed");

// next-cycle implication
`define KLQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("knob level quantizer assertion failed");

`endif

[rtl/knob_lq_pkg.sv]
// shared constants for the knob level quantizer
// no dependencies
package knob_lq_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int RAW_W       = 12;
  localparam int FS_W        = 12;
  localparam int LCNT_W      = 9;
  localparam int LVL_W       = 8;
  localparam int NUM_W       = RAW_W + LCNT_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 12;

  localparam logic [RAW_W-1:0] SAMPLE_MASK = RAW_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [RAW_W-1:0] FLOOR_START = RAW_W'(600) & SAMPLE_MASK;
  localparam logic [LVL_W-1:0] LEVEL_LIMIT = LVL_W'(255);

  localparam logic [FS_W-1:0]   FULL_SCALE_RST  = FS_W'(4095);
  localparam logic [LCNT_W-1:0] LEVEL_COUNT_RST = LCNT_W'(39);

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = CFG_IDX_W'(1);

endpackage

[rtl/knob_level_quantizer_hysteresis_unit.sv]
// knob level quantizer with hysteresis, top level
// on a divide fault the result goes straight to S_FIN; otherwise the serial multipliers
// run, then the held level is kept or saturates, or the serial divider recomputes it;
// no new sample is taken until the result is committed (in_stall is high while busy),
// and the result waits in S_FIN while out_stall holds it; synchronous active-low reset
// restores floor 600, no held level and the register reset values
`include "knob_level_quantizer_hysteresis_unit_defines.svh"

module knob_level_quantizer_hysteresis_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [knob_lq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [knob_lq_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [knob_lq_pkg::RAW_W-1:0]         in_raw_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [knob_lq_pkg::LVL_W-1:0]         out_level,
  output logic                                  out_divide_fault
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam int NW = knob_lq_pkg::NUM_W;

  logic [2:0]                          state_r, state_nxt;
  logic [knob_lq_pkg::FS_W-1:0]        full_scale_r;
  logic [knob_lq_pkg::LCNT_W-1:0]      level_count_r;
  logic [knob_lq_pkg::RAW_W-1:0]       floor_r, floor_nxt;
  logic [knob_lq_pkg::LVL_W-1:0]       held_r, held_nxt;
  logic                                valid_r, valid_nxt;
  logic [knob_lq_pkg::FS_W-1:0]        den_r, den_nxt;
  logic [knob_lq_pkg::LVL_W-1:0]       res_level_r, res_level_nxt;
  logic                                res_fault_r, res_fault_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [knob_lq_pkg::LVL_W-1:0]       out_level_r, out_level_nxt;
  logic                                out_fault_r, out_fault_nxt;

  logic                                accept;
  logic [knob_lq_pkg::RAW_W-1:0]       raw;
  logic [knob_lq_pkg::RAW_W-1:0]       floor_new;
  logic                                fault;
  logic [knob_lq_pkg::RAW_W-1:0]       diff;
  logic [knob_lq_pkg::FS_W-1:0]        den_new;
  logic                                mul_start;
  logic [NW-1:0]                       num, held_den;
  logic                                mul0_done, mul1_done;
  logic [knob_lq_pkg::FS_W-1:0]        half;
  logic                                keep, sat;
  logic                                div_start, div_done;
  logic [knob_lq_pkg::LVL_W-1:0]       div_quo;
  logic                                commit;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign raw       = in_raw_sample & knob_lq_pkg::SAMPLE_MASK;
  assign floor_new = (floor_r > raw) ? raw : floor_r;
  assign fault     = (full_scale_r <= floor_new);
  assign diff      = raw - floor_new;
  assign den_new   = full_scale_r - floor_new;
  assign mul_start = accept && !fault;

  knob_lq_mul u_mul_num (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (diff),
    .mplr  (level_count_r),
    .prod  (num),
    .done  (mul0_done)
  );

  knob_lq_mul u_mul_band (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (den_new),
    .mplr  ({1'b0, held_r}),
    .prod  (held_den),
    .done  (mul1_done)
  );

  // hysteresis window around the held band
  assign half = den_r >> 1;
  assign keep = valid_r && (num >= NW'(half)) &&
                (({1'b0, num} + (NW+1)'(half)) >= {1'b0, held_den}) &&
                ((num - NW'(half)) <= (held_den + NW'(den_r)));
  assign sat  = (num >= (NW'(den_r) << knob_lq_pkg::LVL_W));
  assign div_start = (state_r == S_CHECK) && !keep && !sat;

  knob_lq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den_r),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign commit = (state_r == S_FIN) && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt     = state_r;
    floor_nxt     = floor_r;
    held_nxt      = held_r;
    valid_nxt     = valid_r;
    den_nxt       = den_r;
    res_level_nxt = res_level_r;
    res_fault_nxt = res_fault_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_level_nxt = out_level_r;
    out_fault_nxt = out_fault_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          floor_nxt = floor_new;
          den_nxt   = den_new;
          if (fault) begin
            res_level_nxt = '0;
            res_fault_nxt = 1'b1;
            state_nxt     = S_FIN;
          end else begin
            res_fault_nxt = 1'b0;
            state_nxt     = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mul0_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (keep) begin
          res_level_nxt = held_r;
          state_nxt     = S_FIN;
        end else if (sat) begin
          res_level_nxt = knob_lq_pkg::LEVEL_LIMIT;
          state_nxt     = S_FIN;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_level_nxt = div_quo;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (commit) begin
          held_nxt      = res_level_r;
          valid_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
          out_level_nxt = res_level_r;
          out_fault_nxt = res_fault_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      full_scale_r  <= knob_lq_pkg::FULL_SCALE_RST;
      level_count_r <= knob_lq_pkg::LEVEL_COUNT_RST;
      floor_r       <= knob_lq_pkg::FLOOR_START;
      held_r        <= '0;
      valid_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      floor_r     <= floor_nxt;
      held_r      <= held_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          knob_lq_pkg::CFG_FULL_SCALE: begin
            full_scale_r <= cfg_data[knob_lq_pkg::FS_W-1:0];
          end
          knob_lq_pkg::CFG_LEVEL_COUNT: begin
            level_count_r <= cfg_data[knob_lq_pkg::LCNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    den_r       <= den_nxt;
    res_level_r <= res_level_nxt;
    res_fault_r <= res_fault_nxt;
    out_level_r <= out_level_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_level        = out_level_r;
  assign out_divide_fault = out_fault_r;

  `KLQ_ASSERT_IMPL(a_fault_level_zero, out_valid && out_divide_fault, out_level == '0)
  `KLQ_ASSERT_IMPL(a_floor_never_rises, $past(rst_n), floor_r <= $past(floor_r))
  `KLQ_ASSERT_IMPL(a_mul_lockstep, 1'b1, mul0_done == mul1_done)
  `KLQ_ASSERT_NEXT(a_div_only_from_check, div_start, state_r == S_DIV && !div_done)

endmodule

[rtl/knob_lq_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on knob_lq_pkg
module knob_lq_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [knob_lq_pkg::RAW_W-1:0]        mcand,
  input  logic [knob_lq_pkg::LCNT_W-1:0]       mplr,
  output logic [knob_lq_pkg::NUM_W-1:0]        prod,
  output logic                                 done
);

  localparam int CNT_W = $clog2(knob_lq_pkg::LCNT_W + 1);

  logic [knob_lq_pkg::NUM_W-1:0]  acc_r, acc_nxt;
  logic [knob_lq_pkg::NUM_W-1:0]  mcand_r, mcand_nxt;
  logic [knob_lq_pkg::LCNT_W-1:0] mplr_r, mplr_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;

  always_comb begin
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    mplr_nxt  = mplr_r;
    cnt_nxt   = cnt_r;
    if (start) begin
      acc_nxt   = '0;
      mcand_nxt = knob_lq_pkg::NUM_W'(mcand);
      mplr_nxt  = mplr;
      cnt_nxt   = CNT_W'(knob_lq_pkg::LCNT_W);
    end else if (cnt_r != '0) begin
      if (mplr_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r << 1;
      mplr_nxt  = mplr_r >> 1;
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplr_r  <= mplr_nxt;
  end

  assign prod = acc_r;
  assign done = (cnt_r == '0);

endmodule

[rtl/knob_lq_div.sv]
// restoring divider, one quotient bit per cycle, quotient known below 256
// depends on knob_lq_pkg
module knob_lq_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [knob_lq_pkg::NUM_W-1:0]       num,
  input  logic [knob_lq_pkg::FS_W-1:0]        den,
  output logic [knob_lq_pkg::LVL_W-1:0]       quo,
  output logic                                done
);

  localparam int CNT_W = $clog2(knob_lq_pkg::LVL_W + 1);

  logic [knob_lq_pkg::NUM_W-1:0] rem_r, rem_nxt;
  logic [knob_lq_pkg::NUM_W-1:0] dsr_r, dsr_nxt;
  logic [knob_lq_pkg::LVL_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  always_comb begin
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = num;
      dsr_nxt = knob_lq_pkg::NUM_W'(den) << (knob_lq_pkg::LVL_W - 1);
      quo_nxt = '0;
      cnt_nxt = CNT_W'(knob_lq_pkg::LVL_W);
    end else if (cnt_r != '0) begin
      if (rem_r >= dsr_r) begin
        rem_nxt = rem_r - dsr_r;
        quo_nxt = {quo_r[knob_lq_pkg::LVL_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[knob_lq_pkg::LVL_W-2:0], 1'b0};
      end
      dsr_nxt = dsr_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign quo  = quo_r;
  assign done = (cnt_r == '0);

endmodule
